/* design/bg_tile_fetch_address_decode_defines.svh */
// ----------------------------------------------------------------------------
// bg_tile_fetch_address_decode_defines
// assertion macros shared by the background fetch design
// ----------------------------------------------------------------------------
`ifndef BG_TILE_FETCH_ADDRESS_DECODE_DEFINES_SVH
`define BG_TILE_FETCH_ADDRESS_DECODE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BGTF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bgtf check failed");

// next-cycle implication, checked outside reset
`define BGTF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bgtf check failed");

`endif

/* design/bgtf_pkg.sv */
// ----------------------------------------------------------------------------
// bgtf_pkg
// word types and register indexes of the background tile fetch decode
// ----------------------------------------------------------------------------
`default_nettype none

package bgtf_pkg;

  typedef struct packed {
    logic        kind;
    logic [15:0] h_offset;
    logic [15:0] v_offset;
    logic [15:0] map_entry;
  } in_word_t;

  typedef struct packed {
    logic [15:0] map_address;
    logic [11:0] tile_index;
    logic [7:0]  palette_index;
    logic        high_priority;
    logic [2:0]  fine_x;
    logic [2:0]  fine_y;
  } out_word_t;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_HIRES_MODE     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BIG_TILES      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_SIZE    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAP_BASE       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TILE_DATA_BASE = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TILE_DEPTH     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_PALETTE_BASE   = 3'd6;

  localparam logic [1:0] DEPTH_2BPP = 2'd0;
  localparam logic [1:0] DEPTH_4BPP = 2'd1;
  localparam logic [1:0] DEPTH_8BPP = 2'd2;

  localparam logic KIND_LOCATE = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

endpackage

`default_nettype wire

/* design/bg_tile_fetch_address_decode.sv */
// ----------------------------------------------------------------------------
// bg_tile_fetch_address_decode
// path: the input register feeds the decode logic, whose result is captured in the result register
// throughput: one word per cycle while out_ready is high, set by the input register and result register
// stalls only when both registers are full and out_ready is low
// synchronous active-low reset empties both stages and clears config to 0
// ----------------------------------------------------------------------------
`default_nettype none

`include "bg_tile_fetch_address_decode_defines.svh"

module bg_tile_fetch_address_decode
  import bgtf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire in_word_t            in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output out_word_t                out_word,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  logic        hires_r;
  logic        big_r;
  logic [1:0]  scsize_r;
  logic [15:0] map_base_r;
  logic [15:0] td_base_r;
  logic [1:0]  depth_r;
  logic [7:0]  pal_base_r;

  in_word_t  in_r;
  logic      in_valid_r;
  out_word_t out_r;
  logic      out_valid_r;
  out_word_t out_nxt;
  logic      advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hires_r    <= 1'b0;
      big_r      <= 1'b0;
      scsize_r   <= 2'd0;
      map_base_r <= 16'd0;
      td_base_r  <= 16'd0;
      depth_r    <= 2'd0;
      pal_base_r <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HIRES_MODE:     hires_r    <= cfg_data[0];
        CFG_BIG_TILES:      big_r      <= cfg_data[0];
        CFG_SCREEN_SIZE:    scsize_r   <= cfg_data[1:0];
        CFG_MAP_BASE:       map_base_r <= cfg_data;
        CFG_TILE_DATA_BASE: td_base_r  <= cfg_data;
        CFG_TILE_DEPTH:     depth_r    <= cfg_data[1:0];
        CFG_PALETTE_BASE:   pal_base_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_word;
    end
    if (advance && in_valid_r) begin
      out_r <= out_nxt;
    end
  end

  // coordinate masking
  logic [1:0]  sh_x, sh_y;
  logic [11:0] ext_x, ext_y;
  logic [10:0] hx, vy;
  logic        wide_w;
  logic [7:0]  cx, cy;
  logic [12:0] scx, scy, pos;
  logic [1:0]  depth;
  logic        flip_x, flip_y, inc_x, inc_y;
  logic [9:0]  tile10;
  logic [11:0] td_sh, tile_keep, tile_sum;
  logic [7:0]  pal_term;

  always_comb begin
    sh_x   = {1'b0, hires_r} + {1'b0, big_r} + {1'b0, scsize_r[0]};
    sh_y   = {1'b0, hires_r} + {1'b0, big_r} + {1'b0, scsize_r[1]};
    ext_x  = 12'd256 << sh_x;
    ext_y  = 12'd256 << sh_y;
    hx     = in_r.h_offset[10:0] & 11'(ext_x - 12'd1);
    vy     = in_r.v_offset[10:0] & 11'(ext_y - 12'd1);
    wide_w = hires_r || big_r;

    // map cell and quadrant
    cx  = wide_w ? {1'b0, hx[10:4]} : hx[10:3];
    cy  = big_r ? {1'b0, vy[10:4]} : vy[10:3];
    scx = scsize_r[0] ? 13'd1024 : 13'd0;
    scy = scsize_r[1] ? (scsize_r[0] ? 13'd2048 : 13'd1024) : 13'd0;
    pos = {3'd0, cy[4:0], cx[4:0]} + (cy[5] ? scy : 13'd0) + (cx[5] ? scx : 13'd0);

    // map entry decode
    depth  = (depth_r > DEPTH_8BPP) ? DEPTH_8BPP : depth_r;
    flip_y = in_r.map_entry[15];
    flip_x = in_r.map_entry[14];
    inc_x  = wide_w && (hx[3] != flip_x);
    inc_y  = big_r && (vy[3] != flip_y);
    tile10 = in_r.map_entry[9:0] + {9'd0, inc_x} + {5'd0, inc_y, 4'd0};

    case (depth)
      DEPTH_2BPP: begin
        td_sh     = td_base_r[15:4];
        tile_keep = 12'hfff;
        pal_term  = {3'd0, in_r.map_entry[12:10], 2'd0};
      end
      DEPTH_4BPP: begin
        td_sh     = {1'b0, td_base_r[15:5]};
        tile_keep = 12'h7ff;
        pal_term  = {1'b0, in_r.map_entry[12:10], 4'd0};
      end
      default: begin
        td_sh     = {2'd0, td_base_r[15:6]};
        tile_keep = 12'h3ff;
        pal_term  = 8'd0;
      end
    endcase
    tile_sum = ({2'd0, tile10} + td_sh) & tile_keep;

    out_nxt = '0;
    if (in_r.kind == KIND_LOCATE) begin
      out_nxt.map_address = map_base_r + 16'({pos, 1'b0});
    end else begin
      out_nxt.tile_index    = tile_sum;
      out_nxt.palette_index = pal_base_r + pal_term;
      out_nxt.high_priority = in_r.map_entry[13];
      out_nxt.fine_x        = hx[2:0] ^ {3{flip_x}};
      out_nxt.fine_y        = vy[2:0] ^ {3{flip_y}};
    end
  end

  `BGTF_ASSERT_NEXT(a_stage_moves, in_valid_r && advance, out_valid_r)
  `BGTF_ASSERT_NOW(a_stall_cause, !in_ready, in_valid_r && out_valid_r && !out_ready)
  `BGTF_ASSERT_NOW(a_locate_only_addr, in_valid_r && in_r.kind == KIND_LOCATE, out_nxt.tile_index == 12'd0 && out_nxt.fine_x == 3'd0)
  `BGTF_ASSERT_NOW(a_decode_no_addr, in_valid_r && in_r.kind == KIND_DECODE, out_nxt.map_address == 16'd0)

endmodule

`default_nettype wire
